@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ rtl/irl_pkg.sv @@
// ----------------------------------------------------------------------------
// irl_pkg
// Shared widths, register codes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
package irl_pkg;

  localparam int IR_CHANNELS = 4;
  localparam int CH_W        = 2;
  localparam int RAW_W       = 8;
  localparam int TICK_W      = 16;
  localparam int MM_W        = 10;
  localparam int LID_W       = 15;
  localparam int FRAC_W      = 16;

  localparam int QUAD_W      = 19;
  localparam int LIN_W       = 21;
  localparam int OFS_W       = 27;
  localparam int GAIN_W      = 16;
  localparam int LOFS_W      = 24;
  localparam int SAMP_W      = 28;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 27;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam int MUL_A_W     = 29;
  localparam int MUL_B_W     = 17;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam logic signed [QUAD_W-1:0] QUAD_RST = 19'sd1507;
  localparam logic signed [LIN_W-1:0]  LIN_RST  = -21'sd311034;
  localparam logic [GAIN_W-1:0]        GAIN_RST = 16'd8323;
  localparam logic signed [LOFS_W-1:0] LOFS_RST = -24'sd2862481;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAD = 3'd0,
    CFG_LIN  = 3'd1,
    CFG_OFS1 = 3'd2,
    CFG_OFS2 = 3'd3,
    CFG_OFS3 = 3'd4,
    CFG_OFS4 = 3'd5,
    CFG_GAIN = 3'd6,
    CFG_LOFS = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MA_QUAD   = 2'd0,
    MA_LINSUM = 2'd1,
    MA_RECIP  = 2'd2,
    MA_GAIN   = 2'd3
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_RAW   = 2'd0,
    MB_QUOT  = 2'd1,
    MB_TICKS = 2'd2
  } mul_b_t;

  typedef struct packed {
    logic            load;
    mul_a_t          a_sel;
    mul_b_t          b_sel;
    logic            mul_en;
    logic            win_rd;
    logic            win_wr;
    logic            avg_chk;
    logic            store_en;
    logic [CH_W-1:0] store_ch;
    logic [CH_W-1:0] ch;
    logic            lid_fin;
  } irl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } irl_sts_t;

  function automatic logic signed [OFS_W-1:0] ofs_rst(input logic [CH_W-1:0] ch);
    logic signed [OFS_W-1:0] v;
    case (ch)
      2'd0:    v = 27'sd19704054;
      2'd1:    v = 27'sd20162806;
      2'd2:    v = 27'sd19835126;
      2'd3:    v = 27'sd20162806;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/irl_dp.sv @@
// ----------------------------------------------------------------------------
// irl_dp
// Datapath: config registers, shared multiplier, sample window, running sums,
// result and output registers.
// ----------------------------------------------------------------------------
module irl_dp #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  irl_pkg::irl_cmd_t                cmd,
  output irl_pkg::irl_sts_t                sts,
  input  logic                             cfg_wr,
  input  logic [irl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [irl_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [irl_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import irl_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W   = SAMP_W + $clog2(WINDOW_LEN);
  localparam int QT_W    = SUM_W - FRAC_W - 1;
  localparam int RCP_SH  = 20;
  localparam int AVG_LIM = (1 << MM_W) * WINDOW_LEN;
  localparam logic [MUL_A_W-1:0] RECIP =
    MUL_A_W'(((1 << RCP_SH) + WINDOW_LEN - 1) / WINDOW_LEN);

  // configuration
  logic signed [QUAD_W-1:0] quad_r;
  logic signed [LIN_W-1:0]  lin_r;
  logic signed [OFS_W-1:0]  ofs_r [IR_CHANNELS];
  logic [GAIN_W-1:0]        gain_r;
  logic signed [LOFS_W-1:0] lofs_r;

  // captured item
  logic [RAW_W-1:0]  raw_r [IR_CHANNELS];
  logic [TICK_W-1:0] ticks_r;

  // multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  // window and sums
  logic signed [SAMP_W-1:0]              win_mem [WINDOW_LEN][IR_CHANNELS];
  logic [WINDOW_LEN-1:0][IR_CHANNELS-1:0] win_vld_r;
  logic [SLOT_W-1:0]                     slot_r;
  logic signed [SAMP_W-1:0]              old_r;
  logic                                  old_vld_r;
  logic signed [SUM_W-1:0]               sum_r [IR_CHANNELS];
  logic signed [PROD_W-1:0]              v_full;
  logic signed [SAMP_W-1:0]              samp;
  logic signed [SAMP_W-1:0]              old_term;
  logic signed [SUM_W-1:0]               sum_nxt;
  logic                                  avg_neg_r;
  logic                                  avg_big_r;

  // results
  logic [MM_W-1:0]            ir_mm_r [IR_CHANNELS];
  logic signed [PROD_W-1:0]   lid_sum;
  logic signed [PROD_W-1:0]   lid_adj;
  logic [PROD_W-FRAC_W-1:0]   lid_q;
  logic [LID_W-1:0]           lid_mm;
  logic                       out_valid_r;
  logic [OUT_TDATA_W-1:0]     out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r <= QUAD_RST;
      lin_r  <= LIN_RST;
      for (int c = 0; c < IR_CHANNELS; c++) begin
        ofs_r[c] <= ofs_rst(CH_W'(c));
      end
      gain_r <= GAIN_RST;
      lofs_r <= LOFS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QUAD: quad_r   <= cfg_data[QUAD_W-1:0];
        CFG_LIN:  lin_r    <= cfg_data[LIN_W-1:0];
        CFG_OFS1: ofs_r[0] <= cfg_data[OFS_W-1:0];
        CFG_OFS2: ofs_r[1] <= cfg_data[OFS_W-1:0];
        CFG_OFS3: ofs_r[2] <= cfg_data[OFS_W-1:0];
        CFG_OFS4: ofs_r[3] <= cfg_data[OFS_W-1:0];
        CFG_GAIN: gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_LOFS: lofs_r   <= cfg_data[LOFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < IR_CHANNELS; c++) begin
        raw_r[c] <= in_tdata[c*RAW_W +: RAW_W];
      end
      ticks_r <= in_tdata[IR_CHANNELS*RAW_W +: TICK_W];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.a_sel)
      MA_QUAD:   mul_a = MUL_A_W'(quad_r);
      MA_LINSUM: mul_a = prod_r[MUL_A_W-1:0] + MUL_A_W'(lin_r);
      MA_RECIP:  mul_a = RECIP;
      MA_GAIN:   mul_a = MUL_A_W'(gain_r);
      default:   mul_a = '0;
    endcase
    case (cmd.b_sel)
      MB_RAW:   mul_b = MUL_B_W'(raw_r[cmd.ch]);
      MB_QUOT:  mul_b = MUL_B_W'(sum_r[cmd.ch][SUM_W-2:FRAC_W]);
      MB_TICKS: mul_b = MUL_B_W'(ticks_r);
      default:  mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // calibrated sample, saturated to the window width
  always_comb begin
    v_full = prod_r + PROD_W'(ofs_r[cmd.ch]);
    if (!v_full[PROD_W-1] && (|v_full[PROD_W-2:SAMP_W-1])) begin
      samp = {1'b0, {(SAMP_W-1){1'b1}}};
    end else if (v_full[PROD_W-1] && !(&v_full[PROD_W-2:SAMP_W-1])) begin
      samp = {1'b1, {(SAMP_W-1){1'b0}}};
    end else begin
      samp = v_full[SAMP_W-1:0];
    end
    old_term = old_vld_r ? old_r : '0;
    sum_nxt  = sum_r[cmd.ch] + SUM_W'(samp) - SUM_W'(old_term);
  end

  always_ff @(posedge clk) begin
    if (cmd.win_rd) begin
      old_r <= win_mem[slot_r][cmd.ch];
    end
    if (cmd.win_wr) begin
      win_mem[slot_r][cmd.ch] <= samp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= '0;
      old_vld_r <= 1'b0;
      slot_r    <= '0;
      for (int c = 0; c < IR_CHANNELS; c++) begin
        sum_r[c] <= '0;
      end
    end else begin
      if (cmd.win_rd) begin
        old_vld_r <= win_vld_r[slot_r][cmd.ch];
      end
      if (cmd.win_wr) begin
        win_vld_r[slot_r][cmd.ch] <= 1'b1;
        sum_r[cmd.ch]             <= sum_nxt;
      end
      if (cmd.lid_fin) begin
        slot_r <= (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  // average: negative sums truncate to zero, large quotients clamp
  always_ff @(posedge clk) begin
    if (cmd.avg_chk) begin
      avg_neg_r <= sum_r[cmd.ch][SUM_W-1];
      avg_big_r <= (sum_r[cmd.ch][SUM_W-2:FRAC_W] >= QT_W'(AVG_LIM));
    end
    if (cmd.store_en) begin
      if (avg_neg_r) begin
        ir_mm_r[cmd.store_ch] <= '0;
      end else if (avg_big_r) begin
        ir_mm_r[cmd.store_ch] <= '1;
      end else begin
        ir_mm_r[cmd.store_ch] <= prod_r[RCP_SH+MM_W-1:RCP_SH];
      end
    end
  end

  // lidar: add offset, truncate toward zero, saturate
  always_comb begin
    lid_sum = prod_r + PROD_W'(lofs_r);
    lid_adj = lid_sum + (lid_sum[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : '0);
    lid_q   = lid_adj[PROD_W-1:FRAC_W];
    if (!lid_q[PROD_W-FRAC_W-1] && (|lid_q[PROD_W-FRAC_W-2:LID_W-1])) begin
      lid_mm = {1'b0, {(LID_W-1){1'b1}}};
    end else if (lid_q[PROD_W-FRAC_W-1] && !(&lid_q[PROD_W-FRAC_W-2:LID_W-1])) begin
      lid_mm = {1'b1, {(LID_W-1){1'b0}}};
    end else begin
      lid_mm = lid_q[LID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.lid_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lid_fin) begin
      out_data_r <= {1'b0, lid_mm, ir_mm_r[3], ir_mm_r[2], ir_mm_r[1], ir_mm_r[0]};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.out_busy = out_valid_r & ~out_tready;

endmodule

@@ rtl/irl_ctrl.sv @@
// ----------------------------------------------------------------------------
// irl_ctrl
// Sequencer: walks each channel through the shared multiplier, then the lidar.
// ----------------------------------------------------------------------------
module irl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  irl_pkg::irl_sts_t sts,
  output irl_pkg::irl_cmd_t cmd
);
  import irl_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_MUL_Q   = 7'b0000010,
    ST_MUL_L   = 7'b0000100,
    ST_ACC     = 7'b0001000,
    ST_DIV     = 7'b0010000,
    ST_LID_MUL = 7'b0100000,
    ST_LID_ADD = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;

  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    cmd          = '0;
    cmd.a_sel    = MA_QUAD;
    cmd.b_sel    = MB_RAW;
    cmd.ch       = ch_r;
    cmd.store_ch = ch_r - 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          ch_nxt    = '0;
          state_nxt = ST_MUL_Q;
        end
      end
      ST_MUL_Q: begin
        cmd.mul_en   = 1'b1;
        cmd.store_en = (ch_r != '0);
        state_nxt    = ST_MUL_L;
      end
      ST_MUL_L: begin
        cmd.a_sel  = MA_LINSUM;
        cmd.mul_en = 1'b1;
        cmd.win_rd = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.win_wr = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.a_sel   = MA_RECIP;
        cmd.b_sel   = MB_QUOT;
        cmd.mul_en  = 1'b1;
        cmd.avg_chk = 1'b1;
        if (ch_r == CH_W'(IR_CHANNELS - 1)) begin
          state_nxt = ST_LID_MUL;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_MUL_Q;
        end
      end
      ST_LID_MUL: begin
        cmd.a_sel    = MA_GAIN;
        cmd.b_sel    = MB_TICKS;
        cmd.mul_en   = 1'b1;
        cmd.store_en = 1'b1;
        cmd.store_ch = ch_r;
        state_nxt    = ST_LID_ADD;
      end
      ST_LID_ADD: begin
        // hold until the output register has room
        if (!sts.out_busy) begin
          cmd.lid_fin = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

@@ rtl/ir_lidar_range_linearize_avg.sv @@
// ----------------------------------------------------------------------------
// ir_lidar_range_linearize_avg
// Quadratic IR range calibration with a moving-average window per channel,
// plus linear lidar pulse-width to distance conversion.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in_     | in  | in_tvalid/tready   | 4 x 8-bit IR reading, 16-bit ticks
//  out_    | out | out_tvalid/tready  | 4 x 10-bit mm average, 15-bit lidar mm
//  cfg_    | in  | cfg_valid/ready    | 3-bit register index, 27-bit data
//
//  The sequencer steps through an accept state, per IR channel MUL_Q, MUL_L,
//  ACC and DIV, then LID_MUL and LID_ADD for the lidar, all set by the single
//  shared multiplier (q*x, (p+b)*x, average by reciprocal, gain*ticks). The
//  result is loaded into the output register in LID_ADD, once it has room.
//  The next item is taken while the last result waits in the output register;
//  its results stall only if that register is still full when they are ready.
//  Reset (rst_n low, synchronous) loads the register defaults and marks every
//  window entry empty (reads as zero); no clearing pass is needed.
//  cfg_ready is always high; write registers only while the block is idle.
//
`include "assert_macros.svh"

module ir_lidar_range_linearize_avg #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: ir_raw_1[7:0], ir_raw_2[15:8], ir_raw_3[23:16], ir_raw_4[31:24],
  //           lidar_pulse_ticks[47:32]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [irl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: ir_mm_1[9:0], ir_mm_2[19:10], ir_mm_3[29:20], ir_mm_4[39:30],
  //            lidar_mm[54:40], zero pad[55]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [irl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [irl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import irl_pkg::*;

  irl_cmd_t cmd;
  irl_sts_t sts;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;

  irl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  irl_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // an accepted item is captured and the sequencer leaves idle
  `ASSERT_IMPL(a_load_on_accept, clk, rst_n, in_tvalid && in_tready, cmd.load)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a finished item never overwrites a result that is still waiting
  `ASSERT_IMPL(a_fin_has_room, clk, rst_n, cmd.lid_fin, !(out_tvalid && !out_tready))
  `ASSERT_NEXT(a_fin_shows_result, clk, rst_n, cmd.lid_fin, out_tvalid)

endmodule
